### rtl/core/mrr_pkg.sv
package mrr_pkg;

  // Field widths
  localparam int unsigned TICK_W = 20;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned ATT_W  = 8;
  localparam int unsigned MAXR_W = 4;

  // Default frame limit, bytes including CRC
  localparam int unsigned MAX_FRAME_DEF = 256;

  // Input word types
  localparam logic [1:0] REQ_SENT = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // Result kinds
  localparam logic KIND_ECHO   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADCRC   = 3'd1;
  localparam logic [2:0] ST_RESEND   = 3'd2;
  localparam logic [2:0] ST_GIVEUP   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_RESP_TO = 2'd0;
  localparam logic [1:0] CFG_IB_TO   = 2'd1;
  localparam logic [1:0] CFG_MAX_RES = 2'd2;

  // Configuration reset values
  localparam logic [TICK_W-1:0] RESP_TO_RST = 20'd500000;
  localparam logic [TICK_W-1:0] IB_TO_RST   = 20'd1563;
  localparam logic [MAXR_W-1:0] MAX_RES_RST = 4'd2;

  typedef struct packed {
    logic [TICK_W-1:0] resp_to;
    logic [TICK_W-1:0] ib_to;
    logic [MAXR_W-1:0] max_res;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic [2:0]       status;
    logic [LEN_W-1:0] frame_len;
    logic [7:0]       func_code;
    logic [ATT_W-1:0] next_attempt;
    logic             last;
  } result_t;

  // Results produced by one input word: count (0..2) and the words
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Modbus CRC-16, reflected poly 0xA001, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/modbus_rtu_response_receiver.sv
// Channel | Handshake                        | Payload
// --------+----------------------------------+----------------------------------------------
// in      | in_valid_i / in_ready_o          | req_type_i, rx_byte_i, attempt_i
// out     | out_valid_o / out_ready_i        | kind_o, data_byte_o, status_o, frame_len_o,
//         |                                  | func_code_o, next_attempt_o, last_o
// cfg     | cfg_we_i (no wait)               | cfg_idx_i, cfg_wdata_i
//
// An input word is registered, then handled by the framer: CRC byte step, length
// decode and tick compare are combinational, so one word per cycle while the queue has room.
// A word yields up to two result words; the output side drains one per cycle, while
// out_ready_i is high, from a three-entry result queue; a frame's last byte yields two.
// Reset loads the default timeouts and resend limit and empties the queue.
// The input register stalls only when the queue cannot take two more words.
module modbus_rtu_response_receiver #(
  parameter int unsigned MaxFrame = mrr_pkg::MAX_FRAME_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [7:0]                 rx_byte_i,
  input  logic [mrr_pkg::ATT_W-1:0]  attempt_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       kind_o,
  output logic [7:0]                 data_byte_o,
  output logic [2:0]                 status_o,
  output logic [mrr_pkg::LEN_W-1:0]  frame_len_o,
  output logic [7:0]                 func_code_o,
  output logic [mrr_pkg::ATT_W-1:0]  next_attempt_o,
  output logic                       last_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [mrr_pkg::TICK_W-1:0] cfg_wdata_i
);
  import mrr_pkg::*;

  cfg_t             cfg_q;
  logic             in_valid_q;
  logic [1:0]       req_type_q;
  logic [7:0]       rx_byte_q;
  logic [ATT_W-1:0] attempt_q;
  logic             space;
  logic             fire;
  push_t            push;
  result_t          res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resp_to <= RESP_TO_RST;
      cfg_q.ib_to   <= IB_TO_RST;
      cfg_q.max_res <= MAX_RES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESP_TO: cfg_q.resp_to <= cfg_wdata_i;
        CFG_IB_TO:   cfg_q.ib_to   <= cfg_wdata_i;
        CFG_MAX_RES: cfg_q.max_res <= cfg_wdata_i[MAXR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign fire       = in_valid_q && space;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_type_q <= req_type_i;
      rx_byte_q  <= rx_byte_i;
      attempt_q  <= attempt_i;
    end
  end

  mrr_framer #(
    .MaxFrame(MaxFrame)
  ) u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .req_type_i(req_type_q),
    .rx_byte_i (rx_byte_q),
    .attempt_i (attempt_q),
    .cfg_i     (cfg_q),
    .push_o    (push)
  );

  mrr_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (res)
  );

  assign kind_o         = res.kind;
  assign data_byte_o    = res.data_byte;
  assign status_o       = res.status;
  assign frame_len_o    = res.frame_len;
  assign func_code_o    = res.func_code;
  assign next_attempt_o = res.next_attempt;
  assign last_o         = res.last;

endmodule

### rtl/core/mrr_framer.sv
module mrr_framer #(
  parameter int unsigned MaxFrame = mrr_pkg::MAX_FRAME_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [1:0]                req_type_i,
  input  logic [7:0]                rx_byte_i,
  input  logic [mrr_pkg::ATT_W-1:0] attempt_i,
  input  mrr_pkg::cfg_t             cfg_i,
  output mrr_pkg::push_t            push_o
);
  import mrr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_RECV = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [7:0]        func_q, func_d;
  logic [15:0]       crc_q, crc_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [ATT_W-1:0]  att_q, att_d;

  logic [LEN_W-1:0]  idx_n, len_n;
  logic [7:0]        func_n;
  logic [15:0]       crc_n;
  logic [TICK_W-1:0] tick_n, limit;
  logic              res_ok;
  result_t           r0, r1;
  logic [1:0]        cnt;

  // Frame length from function code and third byte
  function automatic logic [LEN_W-1:0] length_for(input logic [7:0] fc, input logic [7:0] third);
    logic [LEN_W-1:0] l;
    if (fc[7]) begin
      l = LEN_W'(5);
    end else begin
      case (fc)
        8'd1, 8'd2, 8'd3, 8'd4:     l = LEN_W'(third) + LEN_W'(5);
        8'd5, 8'd6, 8'd15, 8'd16:   l = LEN_W'(8);
        default:                    l = LEN_W'(3);
      endcase
    end
    return l;
  endfunction

  // Byte path
  assign idx_n  = idx_q + LEN_W'(1);
  assign crc_n  = crc16_byte(crc_q, rx_byte_i);
  assign func_n = (idx_n == LEN_W'(2)) ? rx_byte_i : func_q;
  assign len_n  = (idx_n == LEN_W'(3)) ? length_for(func_q, rx_byte_i) : len_q;

  // Tick path
  assign tick_n = (tick_q != '1) ? tick_q + TICK_W'(1) : tick_q;
  assign limit  = (phase_q == PH_WAIT) ? cfg_i.resp_to : cfg_i.ib_to;
  assign res_ok = att_q < ATT_W'(cfg_i.max_res);

  // Next state and results
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    len_d   = len_q;
    func_d  = func_q;
    crc_d   = crc_q;
    tick_d  = tick_q;
    att_d   = att_q;
    r0      = '0;
    r1      = '0;
    cnt     = 2'd0;
    if (fire_i) begin
      case (req_type_i)
        REQ_SENT: begin
          idx_d  = '0;
          len_d  = LEN_W'(3);
          func_d = '0;
          crc_d  = 16'hFFFF;
          tick_d = '0;
          att_d  = attempt_i;
          if (attempt_i > ATT_W'(cfg_i.max_res)) begin
            phase_d   = PH_IDLE;
            r0.kind   = KIND_STATUS;
            r0.status = ST_GIVEUP;
            r0.last   = 1'b1;
            cnt       = 2'd1;
          end else begin
            phase_d = PH_WAIT;
          end
        end
        REQ_BYTE: begin
          if (phase_q != PH_IDLE) begin
            phase_d      = PH_RECV;
            tick_d       = '0;
            crc_d        = crc_n;
            idx_d        = idx_n;
            func_d       = func_n;
            len_d        = len_n;
            r0.kind      = KIND_ECHO;
            r0.data_byte = rx_byte_i;
            r1.kind      = KIND_STATUS;
            r1.frame_len = len_n - LEN_W'(2);
            r1.func_code = func_n;
            r1.last      = 1'b1;
            if (idx_n == LEN_W'(3) && len_n > LEN_W'(MaxFrame)) begin
              // length too big for the frame buffer
              phase_d   = PH_IDLE;
              r1.status = ST_OVERFLOW;
              cnt       = 2'd2;
            end else if (idx_n >= LEN_W'(3) && idx_n >= len_n) begin
              // frame complete, CRC over all bytes leaves zero when good
              phase_d   = PH_IDLE;
              r1.status = (crc_n == 16'h0000) ? ST_OK : ST_BADCRC;
              cnt       = 2'd2;
            end else begin
              r0.last = 1'b1;
              cnt     = 2'd1;
            end
          end
        end
        REQ_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (tick_n < limit) begin
              tick_d = tick_n;
            end else begin
              phase_d      = PH_IDLE;
              tick_d       = '0;
              r0.kind      = KIND_STATUS;
              r0.func_code = func_q;
              r0.last      = 1'b1;
              cnt          = 2'd1;
              if (res_ok) begin
                r0.status       = ST_RESEND;
                r0.next_attempt = att_q + ATT_W'(1);
              end else begin
                r0.status = ST_GIVEUP;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign push_o.cnt = cnt;
  assign push_o.r0  = r0;
  assign push_o.r1  = r1;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      len_q   <= LEN_W'(3);
      func_q  <= '0;
      crc_q   <= 16'hFFFF;
      tick_q  <= '0;
      att_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      func_q  <= func_d;
      crc_q   <= crc_d;
      tick_q  <= tick_d;
      att_q   <= att_d;
    end
  end

endmodule

### rtl/core/mrr_result_fifo.sv
module mrr_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrr_pkg::push_t   push_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mrr_pkg::result_t out_o
);
  import mrr_pkg::*;

  localparam int unsigned Depth = 3;

  result_t    mem_q [Depth];
  logic [1:0] rd_q, rd_d;
  logic [1:0] wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] wr_nx;
  logic [1:0] cnt_left;
  logic       pop;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p == 2'(Depth - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o       = mem_q[rd_q];
  assign cnt_left    = cnt_q - {1'b0, pop};
  // room for two words after this cycle's pop
  assign space_o     = cnt_left <= 2'd1;
  assign wr_nx       = inc3(wr_q);

  always_comb begin
    rd_d  = pop ? inc3(rd_q) : rd_q;
    cnt_d = cnt_left + push_i.cnt;
    case (push_i.cnt)
      2'd1:    wr_d = wr_nx;
      2'd2:    wr_d = inc3(wr_nx);
      default: wr_d = wr_q;
    endcase
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nx] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> ({1'b0, cnt_left} + {1'b0, push_i.cnt}) <= 3'(Depth))
    else $error("result queue overflow");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == KIND_STATUS |-> out_o.last)
    else $error("status word not marked last");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rd_q))
    else $error("stalled result word moved");

endmodule
